// ===== design/amm_pkg.sv =====
// shared types and constants of the audio mixing matrix
// no dependencies; every other design file imports this package
package amm_pkg;

    localparam int CHANNELS     = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_WIDTH   = 16;
    localparam int INT_BITS     = 4;
    localparam int FRAC_BITS    = GAIN_WIDTH - INT_BITS;

    localparam int CH_W    = $clog2(CHANNELS);
    localparam int COUNT_W = 4;
    localparam int PROD_W  = SAMPLE_WIDTH + GAIN_WIDTH;

    // adder tree: products summed in groups, then groups summed
    localparam int GROUP    = 4;
    localparam int NGROUP   = (CHANNELS + GROUP - 1) / GROUP;
    localparam int GROUP_SW = PROD_W + $clog2(GROUP);
    localparam int ACC_W    = PROD_W + CH_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = COUNT_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_INPUTS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_OUTPUTS = CFG_INDEX_W'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MIX  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(CHANNELS);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [GAIN_WIDTH-1:0]   gain_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [GROUP_SW-1:0]     group_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic [COUNT_W-1:0]             count_t;
    typedef logic [CH_W-1:0]                chan_t;
    typedef logic [CFG_INDEX_W-1:0]         cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]          cfg_data_t;

endpackage

// ===== design/amm_frame_if.sv =====
// input channel of the mixer: gain loads and sample frames
// depends on amm_pkg
interface amm_frame_if;
    import amm_pkg::*;

    logic    valid;
    logic    ready;
    logic    op;
    chan_t   gain_row;
    chan_t   gain_col;
    gain_t   gain_value;
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;

    modport source
    (
        output valid, op, gain_row, gain_col, gain_value,
        output sample_0, sample_1, sample_2, sample_3,
        output sample_4, sample_5, sample_6, sample_7,
        input  ready
    );

    modport sink
    (
        input  valid, op, gain_row, gain_col, gain_value,
        input  sample_0, sample_1, sample_2, sample_3,
        input  sample_4, sample_5, sample_6, sample_7,
        output ready
    );

endinterface

// ===== design/amm_result_if.sv =====
// output channel of the mixer: one mixed frame per transfer
// depends on amm_pkg
interface amm_result_if;
    import amm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t mix_0;
    sample_t mix_1;
    sample_t mix_2;
    sample_t mix_3;
    sample_t mix_4;
    sample_t mix_5;
    sample_t mix_6;
    sample_t mix_7;

    modport source
    (
        output valid, mix_0, mix_1, mix_2, mix_3, mix_4, mix_5, mix_6, mix_7,
        input  ready
    );

    modport sink
    (
        input  valid, mix_0, mix_1, mix_2, mix_3, mix_4, mix_5, mix_6, mix_7,
        output ready
    );

endinterface

// ===== design/amm_cfg_if.sv =====
// register write channel of the mixer
// depends on amm_pkg
interface amm_cfg_if;
    import amm_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );

endinterface

// ===== design/amm_mult.sv =====
// input register, gain store and product stage of the mixer
// depends on amm_pkg
module amm_mult
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       in_op,
    input  amm_pkg::chan_t                             in_row,
    input  amm_pkg::chan_t                             in_col,
    input  amm_pkg::gain_t                             in_gain,
    input  amm_pkg::sample_t [amm_pkg::CHANNELS-1:0]   in_samples,
    input  amm_pkg::count_t                            active_inputs,
    input  amm_pkg::count_t                            active_outputs,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output amm_pkg::prod_t [amm_pkg::CHANNELS-1:0][amm_pkg::CHANNELS-1:0] out_prod
);
    import amm_pkg::*;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_op_reg;
    chan_t                    s1_row_reg;
    chan_t                    s1_col_reg;
    gain_t                    s1_gain_reg;
    sample_t [CHANNELS-1:0]   s1_samples_reg;

    logic                     s2_valid_reg;
    logic                     s2_valid_next;
    prod_t [CHANNELS-1:0][CHANNELS-1:0] prod_reg;
    prod_t [CHANNELS-1:0][CHANNELS-1:0] prod_next;

    gain_t [CHANNELS-1:0][CHANNELS-1:0] gain_reg;

    logic s2_open;
    logic s1_leave;
    logic s1_load;
    logic s1_mix_move;
    logic in_take;

    // a load leaves stage 1 at once, a mix needs room in stage 2
    assign s2_open     = !s2_valid_reg || out_ready;
    assign s1_load     = s1_valid_reg && (s1_op_reg == OP_LOAD);
    assign s1_mix_move = s1_valid_reg && (s1_op_reg == OP_MIX) && s2_open;
    assign s1_leave    = s1_load || s1_mix_move;
    assign in_ready    = !s1_valid_reg || s1_leave;
    assign in_take     = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_open)
        begin
            s2_valid_next = s1_mix_move;
        end
    end

    // products of channels outside the active counts are forced to zero
    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if ((COUNT_W'(i) < active_inputs) && (COUNT_W'(j) < active_outputs))
                begin
                    prod_next[j][i] = prod_t'(s1_samples_reg[i]) * prod_t'(gain_reg[j][i]);
                end
                else
                begin
                    prod_next[j][i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // gain store clears to zero at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else if (s1_load)
        begin
            gain_reg[s1_row_reg][s1_col_reg] <= s1_gain_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg      <= in_op;
            s1_row_reg     <= in_row;
            s1_col_reg     <= in_col;
            s1_gain_reg    <= in_gain;
            s1_samples_reg <= in_samples;
        end
        if (s1_mix_move)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_prod  = prod_reg;

endmodule

// ===== design/amm_reduce.sv =====
// first adder level of the mixer: partial sums of product groups per output
// depends on amm_pkg
module amm_reduce
(
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic                                                        in_valid,
    output logic                                                        in_ready,
    input  amm_pkg::prod_t  [amm_pkg::CHANNELS-1:0][amm_pkg::CHANNELS-1:0] in_prod,
    output logic                                                        out_valid,
    input  logic                                                        out_ready,
    output amm_pkg::group_t [amm_pkg::CHANNELS-1:0][amm_pkg::NGROUP-1:0]   out_group
);
    import amm_pkg::*;

    logic                                s3_valid_reg;
    logic                                s3_valid_next;
    group_t [CHANNELS-1:0][NGROUP-1:0]   group_reg;
    group_t [CHANNELS-1:0][NGROUP-1:0]   group_next;
    logic                                in_take;

    assign in_ready = !s3_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s3_valid_next = in_ready ? in_valid : s3_valid_reg;
    end

    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                group_next[j][g] = '0;
                for (int k = 0; k < GROUP; k++)
                begin
                    if (g * GROUP + k < CHANNELS)
                    begin
                        group_next[j][g] = group_next[j][g]
                                         + group_t'(in_prod[j][g * GROUP + k]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            group_reg <= group_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_group = group_reg;

endmodule

// ===== design/amm_round.sv =====
// final adder level, rounding and saturation, and output register of the mixer
// depends on amm_pkg
module amm_round
(
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic                                                        in_valid,
    output logic                                                        in_ready,
    input  amm_pkg::group_t [amm_pkg::CHANNELS-1:0][amm_pkg::NGROUP-1:0]   in_group,
    output logic                                                        out_valid,
    input  logic                                                        out_ready,
    output amm_pkg::sample_t [amm_pkg::CHANNELS-1:0]                     out_mix
);
    import amm_pkg::*;

    localparam acc_t HALF_LSB = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t SAT_MAX  = (acc_t'(1) <<< (SAMPLE_WIDTH - 1)) - acc_t'(1);
    localparam acc_t SAT_MIN  = -(acc_t'(1) <<< (SAMPLE_WIDTH - 1));

    logic                     s4_valid_reg;
    logic                     s4_valid_next;
    sample_t [CHANNELS-1:0]   mix_reg;
    sample_t [CHANNELS-1:0]   mix_next;
    acc_t    [CHANNELS-1:0]   acc;
    acc_t    [CHANNELS-1:0]   scaled;
    logic                     in_take;

    assign in_ready = !s4_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s4_valid_next = in_ready ? in_valid : s4_valid_reg;
    end

    // round half up, floor shift to Q1.15, then clamp
    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
        begin
            acc[j] = '0;
            for (int g = 0; g < NGROUP; g++)
            begin
                acc[j] = acc[j] + acc_t'(in_group[j][g]);
            end
            scaled[j] = (acc[j] + HALF_LSB) >>> FRAC_BITS;
            if (scaled[j] > SAT_MAX)
            begin
                mix_next[j] = sample_t'(SAT_MAX);
            end
            else if (scaled[j] < SAT_MIN)
            begin
                mix_next[j] = sample_t'(SAT_MIN);
            end
            else
            begin
                mix_next[j] = scaled[j][SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mix_reg <= mix_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_mix   = mix_reg;

endmodule

// ===== design/audio_mix_matrix.sv =====
// 8x8 audio mixing matrix with gain store, config registers and output register
// depends on amm_pkg, the three channel interfaces, amm_mult, amm_reduce, amm_round
//
// channels: frame (sink) takes gain loads (op 0) and sample frames (op 1);
// result (source) gives one mixed frame for every sample frame; cfg (sink)
// writes active_inputs (index 0) and active_outputs (index 1), other indexes
// are dropped. cfg is always ready; the user must write it only while the block
// is idle, which the block does not enforce. a load writes one Q4.12 gain of
// the 8x8 store and gives no result. output j is the sum of sample_i * gain[j][i]
// over the active inputs, rounded half up and saturated to Q1.15; outputs at or
// beyond active_outputs read zero. throughput: one item per cycle while result
// does not stall; four register stages (input, products, group sums, final sum
// with rounding) each take a new item every cycle. loads and frames keep their
// order, since gains are written at the same stage where products are formed.
// a stall on result fills the stages one by one and then drops frame.ready;
// nothing is lost or repeated.
// reset clears all gains to zero, empties the pipeline and sets both
// counts to eight.
module audio_mix_matrix
(
    input  logic  clk,
    input  logic  rst_n,
    amm_frame_if.sink    frame,
    amm_result_if.source result,
    amm_cfg_if.sink      cfg
);
    import amm_pkg::*;

    count_t active_inputs_reg;
    count_t active_inputs_next;
    count_t active_outputs_reg;
    count_t active_outputs_next;

    sample_t [CHANNELS-1:0] samples;
    sample_t [CHANNELS-1:0] mix;

    logic                                m2r_valid;
    logic                                m2r_ready;
    prod_t  [CHANNELS-1:0][CHANNELS-1:0] m2r_prod;
    logic                                r2o_valid;
    logic                                r2o_ready;
    group_t [CHANNELS-1:0][NGROUP-1:0]   r2o_group;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        active_inputs_next  = active_inputs_reg;
        active_outputs_next = active_outputs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ACTIVE_INPUTS:  active_inputs_next  = cfg.data;
                CFG_ACTIVE_OUTPUTS: active_outputs_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_inputs_reg  <= COUNT_RESET;
            active_outputs_reg <= COUNT_RESET;
        end
        else
        begin
            active_inputs_reg  <= active_inputs_next;
            active_outputs_reg <= active_outputs_next;
        end
    end

    assign samples[0] = frame.sample_0;
    assign samples[1] = frame.sample_1;
    assign samples[2] = frame.sample_2;
    assign samples[3] = frame.sample_3;
    assign samples[4] = frame.sample_4;
    assign samples[5] = frame.sample_5;
    assign samples[6] = frame.sample_6;
    assign samples[7] = frame.sample_7;

    amm_mult u_mult
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (frame.valid),
        .in_ready       (frame.ready),
        .in_op          (frame.op),
        .in_row         (frame.gain_row),
        .in_col         (frame.gain_col),
        .in_gain        (frame.gain_value),
        .in_samples     (samples),
        .active_inputs  (active_inputs_reg),
        .active_outputs (active_outputs_reg),
        .out_valid      (m2r_valid),
        .out_ready      (m2r_ready),
        .out_prod       (m2r_prod)
    );

    amm_reduce u_reduce
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2r_valid),
        .in_ready  (m2r_ready),
        .in_prod   (m2r_prod),
        .out_valid (r2o_valid),
        .out_ready (r2o_ready),
        .out_group (r2o_group)
    );

    amm_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r2o_valid),
        .in_ready  (r2o_ready),
        .in_group  (r2o_group),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_mix   (mix)
    );

    assign result.mix_0 = mix[0];
    assign result.mix_1 = mix[1];
    assign result.mix_2 = mix[2];
    assign result.mix_3 = mix[3];
    assign result.mix_4 = mix[4];
    assign result.mix_5 = mix[5];
    assign result.mix_6 = mix[6];
    assign result.mix_7 = mix[7];

endmodule

// ===== sim/audio_mix_matrix_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for audio_mix_matrix: directed table, then random phases
// depends on amm_pkg, amm_frame_if, amm_result_if, amm_cfg_if and the design itself
module audio_mix_matrix_tb;
    import amm_pkg::*;

    localparam int     LIMIT_CYCLES    = 400000;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     NUM_PHASES      = 10;
    localparam int     PHASE_ITEMS     = 105;
    localparam int     REPORT_MAX      = 10;
    localparam int     BURST_PHASE     = 0;
    localparam int     HOLD_PHASE      = 5;

    localparam longint    ROUND_HALF   = longint'(1) << (FRAC_BITS - 1);
    localparam longint    SAMPLE_MAX_L = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint    SAMPLE_MIN_L = -SAMPLE_MAX_L - 1;
    localparam sample_t   SAMPLE_HI    = sample_t'(SAMPLE_MAX_L);
    localparam sample_t   SAMPLE_LO    = sample_t'(SAMPLE_MIN_L);
    localparam gain_t     GAIN_HI      = {1'b0, {(GAIN_WIDTH - 1){1'b1}}};
    localparam gain_t     GAIN_LO      = {1'b1, {(GAIN_WIDTH - 1){1'b0}}};
    localparam gain_t     GAIN_UNITY   = gain_t'(1 << FRAC_BITS);
    // indexes past the register list, writes there are dropped
    localparam cfg_index_t CFG_SPARE_LO = cfg_index_t'(2);
    localparam cfg_index_t CFG_SPARE_HI = cfg_index_t'(3);

    typedef sample_t [CHANNELS-1:0] sample_vec_t;

    typedef struct packed {
        logic        op;
        chan_t       row;
        chan_t       col;
        gain_t       gain;
        sample_vec_t smp;
    } frame_item_t;

    typedef struct packed {
        frame_item_t item;
        logic        known;
        sample_vec_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    amm_frame_if  frame_ch ();
    amm_result_if result_ch ();
    amm_cfg_if    cfg_ch ();

    audio_mix_matrix uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // predictor state
    gain_t       mix_gains [CHANNELS][CHANNELS];
    count_t      inputs_on;
    count_t      outputs_on;
    sample_vec_t expected_mixes [$];

    directed_row_t directed_rows [$];

    bit idle_off;
    bit stall_off;
    bit hold_off_req;

    int mismatch_count;
    int results_checked;
    int frames_mixed;
    int gains_loaded;
    int cfg_writes;
    int hold_offs_done;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_vec_t vec8(int a0, int a1, int a2, int a3,
                                         int a4, int a5, int a6, int a7);
        sample_vec_t v;
        v[0] = sample_t'(a0);
        v[1] = sample_t'(a1);
        v[2] = sample_t'(a2);
        v[3] = sample_t'(a3);
        v[4] = sample_t'(a4);
        v[5] = sample_t'(a5);
        v[6] = sample_t'(a6);
        v[7] = sample_t'(a7);
        return v;
    endfunction

    function automatic directed_row_t load_row(chan_t r, chan_t c, gain_t g);
        directed_row_t d;
        d = '0;
        d.item.op = OP_LOAD;
        d.item.row = r;
        d.item.col = c;
        d.item.gain = g;
        return d;
    endfunction

    function automatic directed_row_t mix_row(sample_vec_t s, logic known, sample_vec_t want);
        directed_row_t d;
        d = '0;
        d.item.op = OP_MIX;
        d.item.smp = s;
        d.known = known;
        d.want = want;
        return d;
    endfunction

    // sum of sample times gain over the active inputs, round half up, saturate
    function automatic sample_vec_t predict_mix(sample_vec_t smp);
        sample_vec_t mixed;
        longint      acc;
        longint      r;
        int          n_in;
        int          n_out;
        n_in = (inputs_on > CHANNELS) ? CHANNELS : int'(inputs_on);
        n_out = (outputs_on > CHANNELS) ? CHANNELS : int'(outputs_on);
        for (int j = 0; j < CHANNELS; j++)
        begin
            acc = 0;
            if (j < n_out)
            begin
                for (int i = 0; i < n_in; i++)
                    acc += longint'($signed(smp[i])) * longint'(mix_gains[j][i]);
            end
            r = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (r > SAMPLE_MAX_L)
                r = SAMPLE_MAX_L;
            if (r < SAMPLE_MIN_L)
                r = SAMPLE_MIN_L;
            mixed[j] = sample_t'(r);
        end
        return mixed;
    endfunction

    function automatic sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SAMPLE_HI;
        if (r < 16)
            return SAMPLE_LO;
        if (r < 30)
            return sample_t'(int'($urandom_range(0, 128)) - 64);
        return sample_t'($urandom);
    endfunction

    function automatic gain_t pick_gain();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return GAIN_HI;
        if (r < 12)
            return GAIN_LO;
        if (r < 20)
            return ($urandom_range(0, 1) != 0) ? GAIN_UNITY : -GAIN_UNITY;
        if (r < 30)
            return gain_t'(int'($urandom_range(0, 8)) - 4);
        if (r < 60)
            return gain_t'(int'($urandom_range(0, 16384)) - 8192);
        return gain_t'($urandom);
    endfunction

    function automatic frame_item_t random_item();
        frame_item_t it;
        it.op = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_MIX;
        it.row = chan_t'($urandom);
        it.col = chan_t'($urandom);
        it.gain = pick_gain();
        for (int i = 0; i < CHANNELS; i++)
            it.smp[i] = pick_sample();
        return it;
    endfunction

    // mostly back to back, sometimes short pauses, rarely long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_item(frame_item_t it, logic known, sample_vec_t want);
        int gap;
        frame_ch.valid <= 1'b1;
        frame_ch.op <= it.op;
        frame_ch.gain_row <= it.row;
        frame_ch.gain_col <= it.col;
        frame_ch.gain_value <= it.gain;
        frame_ch.sample_0 <= it.smp[0];
        frame_ch.sample_1 <= it.smp[1];
        frame_ch.sample_2 <= it.smp[2];
        frame_ch.sample_3 <= it.smp[3];
        frame_ch.sample_4 <= it.smp[4];
        frame_ch.sample_5 <= it.smp[5];
        frame_ch.sample_6 <= it.smp[6];
        frame_ch.sample_7 <= it.smp[7];
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        // transfer done at this edge
        if (it.op == OP_MIX)
        begin
            expected_mixes.push_back(known ? want : predict_mix(it.smp));
            frames_mixed++;
        end
        else
        begin
            mix_gains[it.row][it.col] = it.gain;
            gains_loaded++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // loads give no result, so allow the pipeline to drain past the last one
    task automatic wait_idle();
        while (expected_mixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_ACTIVE_INPUTS)
            inputs_on = val;
        else if (idx == CFG_ACTIVE_OUTPUTS)
            outputs_on = val;
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int          len;
        int unsigned r;
        logic        val;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_offs_done++;
                val = 1'b0;
                len = HOLD_OFF_CYCLES;
            end
            else if (stall_off || r < 70)
            begin
                val = 1'b1;
                len = stall_off ? 1 : $urandom_range(1, 10);
            end
            else if (r < 95)
            begin
                val = 1'b0;
                len = $urandom_range(1, 3);
            end
            else
            begin
                val = 1'b0;
                len = $urandom_range(8, 40);
            end
            result_ch.ready <= val;
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        sample_vec_t got;
        sample_vec_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.mix_7, result_ch.mix_6, result_ch.mix_5, result_ch.mix_4,
                   result_ch.mix_3, result_ch.mix_2, result_ch.mix_1, result_ch.mix_0};
            if (expected_mixes.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result transfer at cycle %0d", cycle_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_mixes.pop_front();
                for (int j = 0; j < CHANNELS; j++)
                begin
                    if (got[j] !== want[j])
                    begin
                        if (mismatch_count < REPORT_MAX)
                            $display("result %0d mix_%0d: expected %0d, got %0d",
                                     results_checked, j, $signed(want[j]), $signed(got[j]));
                        mismatch_count++;
                    end
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_mixes.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        directed_row_t d;
        cfg_data_t     n_in;
        cfg_data_t     n_out;

        rst_n <= 1'b0;
        frame_ch.valid <= 1'b0;
        frame_ch.op <= OP_LOAD;
        frame_ch.gain_row <= '0;
        frame_ch.gain_col <= '0;
        frame_ch.gain_value <= '0;
        frame_ch.sample_0 <= '0;
        frame_ch.sample_1 <= '0;
        frame_ch.sample_2 <= '0;
        frame_ch.sample_3 <= '0;
        frame_ch.sample_4 <= '0;
        frame_ch.sample_5 <= '0;
        frame_ch.sample_6 <= '0;
        frame_ch.sample_7 <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ACTIVE_INPUTS;
        cfg_ch.data <= '0;

        inputs_on = COUNT_RESET;
        outputs_on = COUNT_RESET;
        for (int j = 0; j < CHANNELS; j++)
            for (int i = 0; i < CHANNELS; i++)
                mix_gains[j][i] = '0;
        idle_off = 1'b0;
        stall_off = 1'b0;
        hold_off_req = 1'b0;

        // gains are all zero out of reset
        directed_rows.push_back(mix_row(vec8(32767, 32767, 32767, 32767,
                                             32767, 32767, 32767, 32767), 1'b1, '0));
        directed_rows.push_back(mix_row(vec8(-32768, -32768, -32768, -32768,
                                             -32768, -32768, -32768, -32768), 1'b1, '0));
        directed_rows.push_back(load_row(3'd0, 3'd0, GAIN_HI));
        directed_rows.push_back(load_row(3'd1, 3'd0, GAIN_LO));
        directed_rows.push_back(load_row(3'd2, 3'd1, GAIN_UNITY));
        directed_rows.push_back(load_row(3'd7, 3'd7, GAIN_UNITY));
        directed_rows.push_back(load_row(3'd4, 3'd3, gain_t'(1)));
        // full scale input into extreme gains saturates both ways
        directed_rows.push_back(mix_row(vec8(32767, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                        vec8(32767, -32768, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(mix_row(vec8(-32768, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                        vec8(-32768, 32767, 0, 0, 0, 0, 0, 0)));
        // half an lsb rounds up on both signs
        directed_rows.push_back(mix_row(vec8(0, 12345, 0, 2048, 0, 0, 0, -7), 1'b0, '0));
        directed_rows.push_back(mix_row(vec8(0, 0, 0, -2048, 0, 0, 0, 32767), 1'b0, '0));
        directed_rows.push_back(mix_row(vec8(0, -32768, 0, -2049, 0, 0, 0, -32768),
                                        1'b0, '0));
        // gain fields on a mix must not reach the store
        d = mix_row(vec8(100, 200, 300, 400, 500, 600, 700, 800), 1'b0, '0);
        d.item.row = 3'd7;
        d.item.col = 3'd7;
        d.item.gain = GAIN_LO;
        directed_rows.push_back(d);
        directed_rows.push_back(mix_row(vec8(0, 0, 0, 0, 0, 0, 0, 32767), 1'b0, '0));
        // samples on a load are ignored
        d = load_row(3'd0, 3'd0, '0);
        d.item.smp = vec8(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        directed_rows.push_back(d);
        directed_rows.push_back(mix_row(vec8(32767, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        directed_rows.push_back(load_row(3'd6, 3'd0, GAIN_HI));
        directed_rows.push_back(load_row(3'd6, 3'd1, GAIN_HI));
        directed_rows.push_back(load_row(3'd6, 3'd2, GAIN_LO));
        directed_rows.push_back(load_row(3'd3, 3'd4, gain_t'(-1)));
        directed_rows.push_back(mix_row(vec8(32767, 32767, 32767, 32767,
                                             32767, 32767, 32767, 32767), 1'b0, '0));
        directed_rows.push_back(mix_row(vec8(-32768, -32768, -32768, -32768,
                                             -32768, -32768, -32768, -32768), 1'b0, '0));
        directed_rows.push_back(mix_row(vec8(1, -1, 4095, -4096, 3, -3, 2047, -2047),
                                        1'b0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);
        frame_ch.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin n_in = cfg_data_t'(8);  n_out = cfg_data_t'(8);  end
                1: begin n_in = cfg_data_t'(1);  n_out = cfg_data_t'(1);  end
                2: begin n_in = cfg_data_t'(0);  n_out = cfg_data_t'(8);  end
                3: begin n_in = cfg_data_t'(8);  n_out = cfg_data_t'(0);  end
                4: begin n_in = cfg_data_t'(15); n_out = cfg_data_t'(15); end
                5: begin n_in = cfg_data_t'(3);  n_out = cfg_data_t'(5);  end
                6: begin n_in = cfg_data_t'(9);  n_out = cfg_data_t'(12); end
                7: begin n_in = cfg_data_t'(5);  n_out = cfg_data_t'(2);  end
                default:
                begin
                    n_in = cfg_data_t'($urandom_range(0, 15));
                    n_out = cfg_data_t'($urandom_range(0, 15));
                end
            endcase
            wait_idle();
            write_reg(CFG_ACTIVE_INPUTS, n_in);
            write_reg(CFG_ACTIVE_OUTPUTS, n_out);
            write_reg((p % 2 == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, cfg_data_t'($urandom));

            idle_off = (p == BURST_PHASE);
            stall_off = (p == BURST_PHASE);
            if (p == HOLD_PHASE)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(), 1'b0, '0);
            frame_ch.valid <= 1'b0;
        end

        wait_idle();

        $display("mixed %0d frames and loaded %0d gains over %0d register settings",
                 frames_mixed, gains_loaded, NUM_PHASES + 1);
        $display("checked %0d results after %0d register writes and %0d long hold-offs",
                 results_checked, cfg_writes, hold_offs_done);
        if (mismatch_count == 0 && expected_mixes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/amm_pkg.sv
design/amm_frame_if.sv
design/amm_result_if.sv
design/amm_cfg_if.sv
design/amm_mult.sv
design/amm_reduce.sv
design/amm_round.sv
design/audio_mix_matrix.sv
sim/audio_mix_matrix_tb.sv
